### src/srgbal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgbal_pkg
// Shared constants, types and elaboration-time tables for the sRGB pixel to
// ASCII shade level core: hundredths quantiser, sRGB linearisation table,
// Rec.709 weights, luminance thresholds and the character ramp.
// ----------------------------------------------------------------------------
package srgbal_pkg;

	localparam int LUM_FRAC_BITS = 16;

	localparam int CHAN_W  = 8;
	localparam int Q_W     = 7;
	localparam int LIN_W   = 16;
	localparam int PROD_W  = 32;
	localparam int SUM_W   = PROD_W + 2;
	localparam int LEVEL_W = 4;
	localparam int CHAR_W  = 7;

	localparam int Q_MAX      = 100;
	localparam int NUM_THR    = 9;
	localparam int MAX_LEVEL  = 9;

	// Rec.709 weights in Q0.16, summing to one
	localparam logic [LIN_W-1:0] W_RED   = 16'd13933;
	localparam logic [LIN_W-1:0] W_GREEN = 16'd46871;
	localparam logic [LIN_W-1:0] W_BLUE  = 16'd4732;

	typedef logic [(1 << CHAN_W)-1:0][Q_W-1:0]        q_tab_t;
	typedef logic [Q_MAX:0][LIN_W-1:0]                lin_tab_t;
	typedef logic [NUM_THR-1:0][LUM_FRAC_BITS-1:0]    thr_tab_t;
	typedef logic [LUM_FRAC_BITS-1:0]                 lum_t;

	typedef struct packed {
		logic s1;
		logic s2;
	} stage_en_t;

	localparam logic [63:0] ONE30 = 64'd1 << 30;

	function automatic logic [63:0] mul30(input logic [63:0] a, input logic [63:0] b);
		return (a * b) >> 30;
	endfunction

	// largest r <= 1.0 in Q0.30 with r^5 <= v, bit by bit
	function automatic logic [63:0] fifth_root30(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] c;
		logic [63:0] p;
		r = 64'd0;
		for (int b = 30; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (c <= ONE30) begin
				p = mul30(c, c);
				p = mul30(p, p);
				p = mul30(p, c);
				if (p <= v)
					r = c;
			end
		end
		return r;
	endfunction

	// (a/211)^2.4 in Q0.30
	function automatic logic [63:0] pow24_30(input logic [63:0] a);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] ac;
		ac = (a > 64'd211) ? 64'd211 : a;
		x  = (ac << 30) / 211;
		x2 = mul30(x, x);
		return mul30(x2, fifth_root30(x2));
	endfunction

	function automatic logic [63:0] lin16(input logic [63:0] q);
		logic [63:0] v30;
		logic [63:0] v16;
		if (q <= 64'd4)
			v30 = (q << 30) / 1292;
		else
			v30 = pow24_30(64'd2 * q + 64'd11);
		v16 = (v30 + (64'd1 << 13)) >> 14;
		return (v16 > 64'd65535) ? 64'd65535 : v16;
	endfunction

	function automatic q_tab_t build_q_table();
		q_tab_t t;
		logic [63:0] c;
		for (int i = 0; i < (1 << CHAN_W); i++) begin
			c = 64'(i);
			t[i] = Q_W'((c * 64'd100 + 64'd254) / 255);
		end
		return t;
	endfunction

	function automatic lin_tab_t build_lin_table();
		lin_tab_t t;
		for (int i = 0; i <= Q_MAX; i++)
			t[i] = LIN_W'(lin16(64'(i)));
		return t;
	endfunction

	// linear images of gray 0.0, 0.1, 0.2 ... 0.8
	function automatic thr_tab_t build_thr_table();
		thr_tab_t t;
		logic [63:0] t30;
		t[0] = '0;
		for (int m = 1; m < NUM_THR; m++) begin
			t30 = pow24_30(64'd20 * 64'(m) + 64'd11);
			t[m] = LUM_FRAC_BITS'((t30 + (64'd1 << (30 - LUM_FRAC_BITS - 1)))
				>> (30 - LUM_FRAC_BITS));
		end
		return t;
	endfunction

	localparam q_tab_t   Q_TABLE   = build_q_table();
	localparam lin_tab_t LIN_TABLE = build_lin_table();
	localparam thr_tab_t THR_TABLE = build_thr_table();

	function automatic logic [CHAR_W-1:0] ramp_char(input logic [LEVEL_W-1:0] level);
		logic [CHAR_W-1:0] ch;
		unique case (level)
			4'd0:    ch = 7'h20; // space
			4'd1:    ch = 7'h2E; // .
			4'd2:    ch = 7'h3A; // :
			4'd3:    ch = 7'h2D; // -
			4'd4:    ch = 7'h3D; // =
			4'd5:    ch = 7'h2B; // +
			4'd6:    ch = 7'h2A; // *
			4'd7:    ch = 7'h23; // #
			4'd8:    ch = 7'h25; // %
			default: ch = 7'h40; // @
		endcase
		return ch;
	endfunction

endpackage

### src/srgbal_chan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srgbal_chan
// One colour channel: quantise to hundredths, then look up the linear sRGB
// value in Q0.16. Two pipeline stages, advanced by the top-level enables.
// ----------------------------------------------------------------------------
module srgbal_chan (
	input  logic                              clk,
	input  srgbal_pkg::stage_en_t             en,
	input  logic [srgbal_pkg::CHAN_W-1:0]     chan,
	output logic [srgbal_pkg::LIN_W-1:0]      lin
);

	logic [srgbal_pkg::Q_W-1:0]   q_s1;
	logic [srgbal_pkg::LIN_W-1:0] lin_s2;

	always_ff @(posedge clk) begin
		if (en.s1)
			q_s1 <= srgbal_pkg::Q_TABLE[chan];
	end

	always_ff @(posedge clk) begin
		if (en.s2)
			lin_s2 <= srgbal_pkg::LIN_TABLE[q_s1];
	end

	assign lin = lin_s2;

endmodule

### src/srgb_pixel_to_ascii_level_core.sv
`timescale 1ns / 1ps
// Latency: 5 register stages; a result passes the quantise, linearise, multiply
// and sum registers before it reaches the output register and can transfer.
// Throughput: one pixel per cycle while out_ready is high; every stage has its
// own ready, so bubbles close up; a stalled output holds only stages behind it.
// Stages: quantise, linearise, weight multiply, sum, threshold compare.
// Reset: arst_n clears the stage valid bits only; payload is not reset.
// ----------------------------------------------------------------------------
// srgb_pixel_to_ascii_level_core
// Converts an 8-bit RGB pixel to a shade level 0..9 and its ramp character
// through linear Rec.709 luminance and nine precomputed linear thresholds.
// ----------------------------------------------------------------------------
module srgb_pixel_to_ascii_level_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [srgbal_pkg::CHAN_W-1:0]       red,
	input  logic [srgbal_pkg::CHAN_W-1:0]       green,
	input  logic [srgbal_pkg::CHAN_W-1:0]       blue,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [srgbal_pkg::LEVEL_W-1:0]      shade_level,
	output logic [srgbal_pkg::CHAR_W-1:0]       ascii_char
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;
	srgbal_pkg::stage_en_t en;

	logic [srgbal_pkg::LIN_W-1:0]  lin_r, lin_g, lin_b;
	logic [srgbal_pkg::PROD_W-1:0] prod_r_s3, prod_g_s3, prod_b_s3;
	logic [srgbal_pkg::SUM_W-1:0]  sum;
	srgbal_pkg::lum_t              lum_s4;
	logic [srgbal_pkg::NUM_THR-1:0] hit;
	logic [srgbal_pkg::LEVEL_W-1:0] level;
	logic [srgbal_pkg::LEVEL_W-1:0] level_s5;
	logic [srgbal_pkg::CHAR_W-1:0]  char_s5;

	// a stage takes a new item when it is empty or its item moves on
	assign rdy_s5 = !v_s5 || out_ready;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign in_ready = rdy_s1;
	assign en.s1    = rdy_s1;
	assign en.s2    = rdy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	srgbal_chan u_chan_r (.clk(clk), .en(en), .chan(red),   .lin(lin_r));
	srgbal_chan u_chan_g (.clk(clk), .en(en), .chan(green), .lin(lin_g));
	srgbal_chan u_chan_b (.clk(clk), .en(en), .chan(blue),  .lin(lin_b));

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			prod_r_s3 <= srgbal_pkg::PROD_W'(lin_r) * srgbal_pkg::PROD_W'(srgbal_pkg::W_RED);
			prod_g_s3 <= srgbal_pkg::PROD_W'(lin_g) * srgbal_pkg::PROD_W'(srgbal_pkg::W_GREEN);
			prod_b_s3 <= srgbal_pkg::PROD_W'(lin_b) * srgbal_pkg::PROD_W'(srgbal_pkg::W_BLUE);
		end
	end

	assign sum = srgbal_pkg::SUM_W'(prod_r_s3) + srgbal_pkg::SUM_W'(prod_g_s3)
		+ srgbal_pkg::SUM_W'(prod_b_s3);

	// weights sum to one, so the Q0.32 sum stays below 2^32
	always_ff @(posedge clk) begin
		if (rdy_s4)
			lum_s4 <= sum[srgbal_pkg::PROD_W-1 -: srgbal_pkg::LUM_FRAC_BITS];
	end

	always_comb begin
		level = '0;
		for (int m = 0; m < srgbal_pkg::NUM_THR; m++) begin
			hit[m] = (lum_s4 <= srgbal_pkg::THR_TABLE[m]);
			level  = level + srgbal_pkg::LEVEL_W'(hit[m]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			level_s5 <= level;
			char_s5  <= srgbal_pkg::ramp_char(level);
		end
	end

	assign out_valid   = v_s5;
	assign shade_level = level_s5;
	assign ascii_char  = char_s5;

`ifndef NO_ASSERTIONS
	a_char_matches_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ascii_char == srgbal_pkg::ramp_char(shade_level))
		else $error("ascii_char does not match shade_level");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> shade_level <= srgbal_pkg::LEVEL_W'(srgbal_pkg::MAX_LEVEL))
		else $error("shade_level out of range");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !rdy_s5) |=> (v_s4 && $stable(lum_s4)))
		else $error("stalled luminance stage lost its item");
`endif

endmodule
